// ----- src/spbe_pkg.sv -----
// ----------------------------------------------------------------------------
// spbe_pkg: shared types and constants for the boundary edge extractor
// Field widths, register indexes, side codes and the item handed to the
// point emitter.
// ----------------------------------------------------------------------------
package spbe_pkg;

  localparam int COORD_W   = 12;              // pixel column / row
  localparam int TYPE_W    = 6;               // material type code
  localparam int MASK_W    = 1 << TYPE_W;     // one solid bit per type
  localparam int DIM_W     = COORD_W + 1;     // sizes up to 2^COORD_W
  localparam int END_W     = COORD_W + 2;     // start + size before clipping
  localparam int SCALE_W   = 24;              // unsigned Q8.16
  localparam int PT_W      = 36;              // unsigned Q20.16
  localparam int SIDE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int IN_W      = 56;              // 54 payload bits padded to bytes
  localparam int OUT_W     = 2 * PT_W;        // 72 bits, whole bytes

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORLD_WIDTH    = 3'd0,
    CFG_WORLD_HEIGHT   = 3'd1,
    CFG_REGION_START_X = 3'd2,
    CFG_REGION_START_Y = 3'd3,
    CFG_REGION_WIDTH   = 3'd4,
    CFG_REGION_HEIGHT  = 3'd5,
    CFG_PIXEL_SCALE    = 3'd6,
    CFG_SOLID_MASK     = 3'd7
  } cfg_reg_t;

  localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd3;

  // Exposed side flags, bit 0 top, 1 bottom, 2 left, 3 right.
  typedef struct packed {
    logic [PT_W-1:0] x0;   // x * scale
    logic [PT_W-1:0] x1;   // (x + 1) * scale
    logic [PT_W-1:0] y0;   // y * scale
    logic [PT_W-1:0] y1;   // (y + 1) * scale
    logic [3:0]      edges;
  } edge_item_t;

endpackage

// ----- src/solid_pixel_boundary_edges.sv -----
// ----------------------------------------------------------------------------
// solid_pixel_boundary_edges: boundary edge extraction for solid pixels
// Turns grid pixels with their neighbor types into scaled unit edge points.
// ----------------------------------------------------------------------------
// Each transfer on the input stream is one pixel: its column and row and the
// material types of the pixel and its four neighbors. A type counts as solid
// when its bit in solid_mask is set, and a neighbor outside the world is never
// solid. A solid pixel inside the traced region (clipped to the world) emits,
// for each exposed side in the order top, bottom, left, right, the two end
// points of that unit edge, each corner scaled by pixel_scale into Q20.16;
// tuser carries the side and tlast marks the pixel's final point. Pixels that
// emit nothing flow at one per cycle while the stages ahead do not stall. A
// pixel with k exposed sides holds the point emitter for 2k points, one point
// per cycle while the sink accepts them, and the three stages in front keep
// filling. After the pixel's transfer, stage 1 looks up the solid bits and
// clips the region, stage 2 tests the bounds and forms the x and y products,
// stage 3 adds one scale step for the far corners, and the emitter loads the
// output register. Configuration writes are taken every cycle and must only
// arrive while no pixel is in flight.
// ----------------------------------------------------------------------------
module solid_pixel_boundary_edges import spbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // Pixel stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pixel_x [11:0], pixel_y [23:12], center_type [29:24], up_type [35:30],
  // down_type [41:36], left_type [47:42], right_type [53:48], zero [55:54]
  input  logic [IN_W-1:0]      s_axis_tdata,
  // Edge point stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // point_x [35:0], point_y [71:36]
  output logic [SIDE_W-1:0]    m_axis_tuser,   // edge_side [1:0]
  output logic                 m_axis_tlast
);

  // Configuration registers
  logic [DIM_W-1:0]   world_width;
  logic [DIM_W-1:0]   world_height;
  logic [COORD_W-1:0] region_start_x;
  logic [COORD_W-1:0] region_start_y;
  logic [DIM_W-1:0]   region_width;
  logic [DIM_W-1:0]   region_height;
  logic [SCALE_W-1:0] pixel_scale;
  logic [MASK_W-1:0]  solid_mask;

  // The port never pushes back; each accepted write updates its register in the following cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_width    <= DIM_W'(1 << COORD_W);
      world_height   <= DIM_W'(1 << COORD_W);
      region_start_x <= '0;
      region_start_y <= '0;
      region_width   <= DIM_W'(1 << COORD_W);
      region_height  <= DIM_W'(1 << COORD_W);
      pixel_scale    <= SCALE_W'(65536);
      solid_mask     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WORLD_WIDTH:    world_width    <= cfg_data[DIM_W-1:0];
        CFG_WORLD_HEIGHT:   world_height   <= cfg_data[DIM_W-1:0];
        CFG_REGION_START_X: region_start_x <= cfg_data[COORD_W-1:0];
        CFG_REGION_START_Y: region_start_y <= cfg_data[COORD_W-1:0];
        CFG_REGION_WIDTH:   region_width   <= cfg_data[DIM_W-1:0];
        CFG_REGION_HEIGHT:  region_height  <= cfg_data[DIM_W-1:0];
        CFG_PIXEL_SCALE:    pixel_scale    <= cfg_data[SCALE_W-1:0];
        CFG_SOLID_MASK:     solid_mask     <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake: a stage takes new data when it is empty or its contents
  // move on in the same cycle.
  // --------------------------------------------------------------------------
  logic v1, v2, v3;
  logic ready1, ready2, ready3;
  logic emit_ready;
  logic keep2;

  assign ready3        = !v3 || emit_ready;
  assign ready2        = !v2 || ready3;
  assign ready1        = !v1 || ready2;
  assign s_axis_tready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= s_axis_tvalid;
      if (ready2) v2 <= v1;
      // Drop pixels that expose no edge here.
      if (ready3) v3 <= v2 && keep2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: unpacked pixel; look up solid bits, clip the region to the world
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] s1_x, s1_y;
  logic [TYPE_W-1:0]  s1_ct, s1_ut, s1_dt, s1_lt, s1_rt;
  logic [END_W-1:0]   s1_sum_x, s1_sum_y;
  logic [END_W-1:0]   s1_end_x, s1_end_y;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && ready1) begin
      s1_x  <= s_axis_tdata[11:0];
      s1_y  <= s_axis_tdata[23:12];
      s1_ct <= s_axis_tdata[29:24];
      s1_ut <= s_axis_tdata[35:30];
      s1_dt <= s_axis_tdata[41:36];
      s1_lt <= s_axis_tdata[47:42];
      s1_rt <= s_axis_tdata[53:48];
    end
  end

  assign s1_sum_x = {2'b00, region_start_x} + {1'b0, region_width};
  assign s1_sum_y = {2'b00, region_start_y} + {1'b0, region_height};
  assign s1_end_x = (s1_sum_x > {1'b0, world_width})  ? {1'b0, world_width}  : s1_sum_x;
  assign s1_end_y = (s1_sum_y > {1'b0, world_height}) ? {1'b0, world_height} : s1_sum_y;

  // --------------------------------------------------------------------------
  // Stage 2: region and world bounds, exposed sides, corner products
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] s2_x, s2_y;
  logic [END_W-1:0]   s2_end_x, s2_end_y;
  logic               s2_c_s, s2_u_s, s2_d_s, s2_l_s, s2_r_s;
  logic               s2_inside;
  logic               s2_top, s2_bottom, s2_left, s2_right;
  logic [3:0]         s2_edges;
  logic [PT_W-1:0]    s2_xs, s2_ys;

  always_ff @(posedge clk) begin
    if (v1 && ready2) begin
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_end_x <= s1_end_x;
      s2_end_y <= s1_end_y;
      s2_c_s   <= solid_mask[s1_ct];
      s2_u_s   <= solid_mask[s1_ut];
      s2_d_s   <= solid_mask[s1_dt];
      s2_l_s   <= solid_mask[s1_lt];
      s2_r_s   <= solid_mask[s1_rt];
    end
  end

  assign s2_inside = (s2_x >= region_start_x) && ({2'b00, s2_x} < s2_end_x) &&
                     (s2_y >= region_start_y) && ({2'b00, s2_y} < s2_end_y);

  // Neighbors past the world edge never cover a side.
  assign s2_top    = !((s2_y != '0) && s2_u_s);
  assign s2_bottom = !((({1'b0, s2_y} + DIM_W'(1)) < world_height) && s2_d_s);
  assign s2_left   = !((s2_x != '0) && s2_l_s);
  assign s2_right  = !((({1'b0, s2_x} + DIM_W'(1)) < world_width) && s2_r_s);

  assign s2_edges = (s2_inside && s2_c_s) ?
                    {s2_right, s2_left, s2_bottom, s2_top} : 4'b0000;
  assign keep2    = s2_edges != 4'b0000;

  assign s2_xs = PT_W'(s2_x) * PT_W'(pixel_scale);
  assign s2_ys = PT_W'(s2_y) * PT_W'(pixel_scale);

  // --------------------------------------------------------------------------
  // Stage 3: far corners are one scale step beyond the near ones
  // --------------------------------------------------------------------------
  logic [PT_W-1:0] s3_xs, s3_ys;
  logic [3:0]      s3_edges;
  edge_item_t      s3_item;

  always_ff @(posedge clk) begin
    if (v2 && keep2 && ready3) begin
      s3_xs    <= s2_xs;
      s3_ys    <= s2_ys;
      s3_edges <= s2_edges;
    end
  end

  always_comb begin
    s3_item.x0    = s3_xs;
    s3_item.x1    = s3_xs + PT_W'(pixel_scale);
    s3_item.y0    = s3_ys;
    s3_item.y1    = s3_ys + PT_W'(pixel_scale);
    s3_item.edges = s3_edges;
  end

  // --------------------------------------------------------------------------
  // Stage 4: walk the exposed sides into the output register
  // --------------------------------------------------------------------------
  spbe_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (v3),
    .item_ready    (emit_ready),
    .item          (s3_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- src/spbe_emit.sv -----
// ----------------------------------------------------------------------------
// spbe_emit: edge point emitter
// Holds one pixel's scaled corners and walks its exposed sides, two points
// per side, into an output register.
// ----------------------------------------------------------------------------
module spbe_emit import spbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  edge_item_t        item,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // point_x [35:0], point_y [71:36]
  output logic [SIDE_W-1:0] m_axis_tuser,   // edge_side [1:0]
  output logic              m_axis_tlast
);

  logic              e_valid;
  logic [PT_W-1:0]   x0, x1, y0, y1;
  logic [3:0]        rem;
  logic              phase;

  logic              o_valid;
  logic [PT_W-1:0]   o_x, o_y;
  logic [SIDE_W-1:0] o_side;
  logic              o_last;

  logic              out_free;
  logic              issue;
  logic              only_one;
  logic              issue_last;
  logic [3:0]        sel;
  logic [SIDE_W-1:0] cur_side;
  logic [PT_W-1:0]   pt_x, pt_y;

  // Lowest pending side goes first: top, bottom, left, right.
  always_comb begin
    sel      = 4'b1000;
    cur_side = SIDE_RIGHT;
    if (rem[0]) begin
      sel      = 4'b0001;
      cur_side = SIDE_TOP;
    end else if (rem[1]) begin
      sel      = 4'b0010;
      cur_side = SIDE_BOTTOM;
    end else if (rem[2]) begin
      sel      = 4'b0100;
      cur_side = SIDE_LEFT;
    end
  end

  always_comb begin
    case (cur_side)
      SIDE_TOP: begin
        pt_x = phase ? x1 : x0;
        pt_y = y0;
      end
      SIDE_BOTTOM: begin
        pt_x = phase ? x0 : x1;
        pt_y = y1;
      end
      SIDE_LEFT: begin
        pt_x = x0;
        pt_y = phase ? y0 : y1;
      end
      default: begin
        pt_x = x1;
        pt_y = phase ? y1 : y0;
      end
    endcase
  end

  assign out_free   = !o_valid || m_axis_tready;
  assign issue      = e_valid && out_free;
  assign only_one   = (rem & ~sel) == 4'b0000;
  assign issue_last = issue && phase && only_one;
  assign item_ready = !e_valid || issue_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      phase   <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        e_valid <= 1'b1;
        phase   <= 1'b0;
      end else if (issue) begin
        phase <= !phase;
        if (issue_last) begin
          e_valid <= 1'b0;
        end
      end
      if (out_free) begin
        o_valid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      x0  <= item.x0;
      x1  <= item.x1;
      y0  <= item.y0;
      y1  <= item.y1;
      rem <= item.edges;
    end else if (issue && phase) begin
      rem <= rem & ~sel;
    end
    if (issue) begin
      o_x    <= pt_x;
      o_y    <= pt_y;
      o_side <= cur_side;
      o_last <= phase && only_one;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {o_y, o_x};
  assign m_axis_tuser  = o_side;
  assign m_axis_tlast  = o_last;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for solid_pixel_boundary_edges
// Streams pixels through the block and compares every edge point it emits
// against a local edge predictor. A short directed plan walks the register
// extremes and the out-of-world, out-of-region and not-solid cases; random
// register settings and random pixels follow. Both stream sides idle at
// random, and at one point the point sink holds off long enough to back the
// block up into its pixel input.
// ----------------------------------------------------------------------------
module testbench import spbe_pkg::*; ();

  localparam int DRAIN    = 12;       // pipeline depth plus margin
  localparam int HOLD_OFF = 300;      // long sink stall, in cycles
  localparam int LIMIT    = 250000;   // watchdog, in cycles
  localparam int PHASES   = 4;
  localparam int PER_PHASE = 26;

  // Exposed-side masks, one bit per side code.
  localparam logic [3:0] EXP_NONE   = 4'b0000;
  localparam logic [3:0] EXP_TOP    = 4'b0001 << SIDE_TOP;
  localparam logic [3:0] EXP_BOTTOM = 4'b0001 << SIDE_BOTTOM;
  localparam logic [3:0] EXP_LEFT   = 4'b0001 << SIDE_LEFT;
  localparam logic [3:0] EXP_RIGHT  = 4'b0001 << SIDE_RIGHT;
  localparam logic [3:0] EXP_ALL    = EXP_TOP | EXP_BOTTOM | EXP_LEFT | EXP_RIGHT;

  typedef struct {
    logic [COORD_W-1:0] x, y;
    logic [TYPE_W-1:0]  c, u, d, l, r;   // center, up, down, left, right
  } pixel_t;

  typedef struct {
    logic [PT_W-1:0]   x, y;
    logic [SIDE_W-1:0] side;
    logic              last;
  } point_t;

  typedef struct {
    logic [DIM_W-1:0]   world_w, world_h;
    logic [COORD_W-1:0] start_x, start_y;
    logic [DIM_W-1:0]   region_w, region_h;
    logic [SCALE_W-1:0] scale;
    logic [MASK_W-1:0]  mask;
  } regs_t;

  typedef enum {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    cfg_reg_t           idx;
    logic [CFG_DAT_W-1:0] data;
    pixel_t             pix;
    bit                 typed;   // sides below are given, not predicted
    logic [3:0]         sides;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic [SIDE_W-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;

  regs_t  regs;               // register copy the predictor works from
  point_t points_due[$];      // edge points still to come, oldest first
  row_t   plan[$];
  int     fails = 0;
  int     cycles = 0;
  bit     hold_off_req = 1'b0;
  bit     src_calm = 1'b0, snk_calm = 1'b0;
  int     src_left = 0, snk_left = 0;

  solid_pixel_boundary_edges dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("solid_pixel_boundary_edges: mismatch");
      $finish;
    end
  end

  // Draw an idle count; runs of calm items give stretches without gaps.
  function automatic int draw_wait(ref bit calm, ref int left);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(4, 24);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic int region_end(int start, int size, int world);
    return (start + size > world) ? world : start + size;
  endfunction

  // Decide which sides of a pixel face non-solid material.
  function automatic logic [3:0] exposed_sides(pixel_t p);
    int ex, ey, x, y;
    logic [3:0] s;
    ex = region_end(regs.start_x, regs.region_w, regs.world_w);
    ey = region_end(regs.start_y, regs.region_h, regs.world_h);
    x = p.x;
    y = p.y;
    if (x < int'(regs.start_x) || x >= ex || y < int'(regs.start_y) || y >= ey)
      return EXP_NONE;
    if (!regs.mask[p.c])
      return EXP_NONE;
    s = EXP_NONE;
    // Neighbors beyond the world edge never count as solid.
    if (!(y > 0 && regs.mask[p.u]))                     s |= EXP_TOP;
    if (!(y + 1 < int'(regs.world_h) && regs.mask[p.d])) s |= EXP_BOTTOM;
    if (!(x > 0 && regs.mask[p.l]))                     s |= EXP_LEFT;
    if (!(x + 1 < int'(regs.world_w) && regs.mask[p.r])) s |= EXP_RIGHT;
    return s;
  endfunction

  function automatic void push_point(longint cx, longint cy, logic [SIDE_W-1:0] side);
    point_t pt;
    pt.x    = PT_W'(cx * longint'(regs.scale));
    pt.y    = PT_W'(cy * longint'(regs.scale));
    pt.side = side;
    pt.last = 1'b0;
    points_due = {points_due, pt};
  endfunction

  // Queue the end points of every exposed unit edge, top to right.
  function automatic void queue_edge_points(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                            logic [3:0] sides);
    longint x0, x1, y0, y1;
    x0 = x;
    x1 = x0 + 1;
    y0 = y;
    y1 = y0 + 1;
    if (sides & EXP_TOP) begin
      push_point(x0, y0, SIDE_TOP);
      push_point(x1, y0, SIDE_TOP);
    end
    if (sides & EXP_BOTTOM) begin
      push_point(x1, y1, SIDE_BOTTOM);
      push_point(x0, y1, SIDE_BOTTOM);
    end
    if (sides & EXP_LEFT) begin
      push_point(x0, y1, SIDE_LEFT);
      push_point(x0, y0, SIDE_LEFT);
    end
    if (sides & EXP_RIGHT) begin
      push_point(x1, y0, SIDE_RIGHT);
      push_point(x1, y1, SIDE_RIGHT);
    end
    if (sides != EXP_NONE)
      points_due[points_due.size() - 1].last = 1'b1;
  endfunction

  // Mostly pixels inside the clipped region, so the solid tests get exercised.
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int ex, ey;
    ex = region_end(regs.start_x, regs.region_w, regs.world_w);
    ey = region_end(regs.start_y, regs.region_h, regs.world_h);
    p.x = COORD_W'($urandom);
    p.y = COORD_W'($urandom);
    if ($urandom_range(0, 4) != 0 && ex > int'(regs.start_x) && ey > int'(regs.start_y)) begin
      p.x = COORD_W'($urandom_range(regs.start_x, ex - 1));
      p.y = COORD_W'($urandom_range(regs.start_y, ey - 1));
    end
    p.c = TYPE_W'($urandom);
    p.u = TYPE_W'($urandom);
    p.d = TYPE_W'($urandom);
    p.l = TYPE_W'($urandom);
    p.r = TYPE_W'($urandom);
    // Uniform neighborhoods give interior pixels with few or no edges.
    if ($urandom_range(0, 3) == 0)
      {p.u, p.d, p.l, p.r} = {4{p.c}};
    return p;
  endfunction

  function automatic row_t write_row(cfg_reg_t idx, logic [CFG_DAT_W-1:0] data);
    row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.data  = data;
    r.pix   = '{default: '0};
    r.typed = 1'b0;
    r.sides = EXP_NONE;
    return r;
  endfunction

  function automatic row_t pixel_row(int x, int y, int c, int u, int d, int l, int r_t,
                                     bit typed, logic [3:0] sides);
    row_t r;
    r.kind  = ROW_PIXEL;
    r.idx   = CFG_WORLD_WIDTH;
    r.data  = '0;
    r.pix   = '{COORD_W'(x), COORD_W'(y), TYPE_W'(c), TYPE_W'(u), TYPE_W'(d),
                TYPE_W'(l), TYPE_W'(r_t)};
    r.typed = typed;
    r.sides = sides;
    return r;
  endfunction

  // Append one row to the directed plan.
  function automatic void add_row(row_t r);
    plan = {plan, r};
  endfunction

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WORLD_WIDTH:    regs.world_w  = data[DIM_W-1:0];
      CFG_WORLD_HEIGHT:   regs.world_h  = data[DIM_W-1:0];
      CFG_REGION_START_X: regs.start_x  = data[COORD_W-1:0];
      CFG_REGION_START_Y: regs.start_y  = data[COORD_W-1:0];
      CFG_REGION_WIDTH:   regs.region_w = data[DIM_W-1:0];
      CFG_REGION_HEIGHT:  regs.region_h = data[DIM_W-1:0];
      CFG_PIXEL_SCALE:    regs.scale    = data[SCALE_W-1:0];
      CFG_SOLID_MASK:     regs.mask     = data[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one pixel and queue its points once the transfer happens.
  task automatic send_pixel(pixel_t p, bit typed, logic [3:0] sides);
    int gap;
    gap = draw_wait(src_calm, src_left);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {2'b00, p.r, p.l, p.d, p.u, p.c, p.y, p.x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    queue_edge_points(p.x, p.y, typed ? sides : exposed_sides(p));
  endtask

  // Drop the pixel stream and wait until the block has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Point sink: random back-pressure, one long hold-off on request.
  initial begin
    int gap;
    point_t want;
    wait (rst == 1'b0);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_req = 1'b0;
      end
      gap = draw_wait(snk_calm, snk_left);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (points_due.size() == 0) begin
        $error("edge point with none outstanding: x %h y %h side %0d",
               m_axis_tdata[PT_W-1:0], m_axis_tdata[OUT_W-1:PT_W], m_axis_tuser);
        fails++;
      end else begin
        want = points_due.pop_front();
        if (m_axis_tdata[PT_W-1:0] !== want.x) begin
          $error("point_x: expected %h, got %h", want.x, m_axis_tdata[PT_W-1:0]);
          fails++;
        end
        if (m_axis_tdata[OUT_W-1:PT_W] !== want.y) begin
          $error("point_y: expected %h, got %h", want.y, m_axis_tdata[OUT_W-1:PT_W]);
          fails++;
        end
        if (m_axis_tuser !== want.side) begin
          $error("edge_side: expected %0d, got %0d", want.side, m_axis_tuser);
          fails++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_point: expected %0b, got %0b", want.last, m_axis_tlast);
          fails++;
        end
      end
    end
  end

  initial begin
    bit pending;
    int ww, wh, sx, sy, rw, rh;
    logic [CFG_DAT_W-1:0] vals[8];

    regs = '{world_w: 4096, world_h: 4096, start_x: 0, start_y: 0,
             region_w: 4096, region_h: 4096, scale: 65536, mask: '0};

    // Reset defaults: nothing is solid, so nothing comes out.
    add_row(pixel_row(0, 0, 0, 0, 0, 0, 0, 1, EXP_NONE));
    add_row(pixel_row(4095, 4095, 63, 63, 63, 63, 63, 1, EXP_NONE));
    // Every type solid: only the world border is exposed.
    add_row(write_row(CFG_SOLID_MASK, '1));
    add_row(pixel_row(0, 0, 5, 5, 5, 5, 5, 1, EXP_TOP | EXP_LEFT));
    add_row(pixel_row(4095, 4095, 63, 63, 63, 63, 63, 1, EXP_BOTTOM | EXP_RIGHT));
    add_row(pixel_row(100, 200, 7, 7, 7, 7, 7, 1, EXP_NONE));
    // Only the lowest and highest type codes solid.
    add_row(write_row(CFG_SOLID_MASK, 64'h8000_0000_0000_0001));
    add_row(pixel_row(10, 10, 63, 1, 1, 1, 1, 1, EXP_ALL));
    add_row(pixel_row(10, 10, 0, 63, 0, 1, 62, 1, EXP_LEFT | EXP_RIGHT));
    add_row(pixel_row(10, 10, 1, 1, 1, 1, 1, 1, EXP_NONE));
    add_row(pixel_row(10, 10, 0, 1, 0, 0, 0, 1, EXP_TOP));
    add_row(pixel_row(10, 10, 0, 0, 2, 0, 0, 1, EXP_BOTTOM));
    // One-pixel world: every neighbor lies outside, whatever its type.
    add_row(write_row(CFG_WORLD_WIDTH, 1));
    add_row(write_row(CFG_WORLD_HEIGHT, 1));
    add_row(pixel_row(0, 0, 0, 0, 0, 0, 0, 1, EXP_ALL));
    add_row(pixel_row(1, 0, 0, 0, 0, 0, 0, 1, EXP_NONE));
    add_row(pixel_row(0, 1, 0, 0, 0, 0, 0, 1, EXP_NONE));
    // Largest scale at the far corner.
    add_row(write_row(CFG_WORLD_WIDTH, 4096));
    add_row(write_row(CFG_WORLD_HEIGHT, 4096));
    add_row(write_row(CFG_PIXEL_SCALE, 24'hFF_FFFF));
    add_row(pixel_row(4095, 4095, 63, 63, 63, 63, 63, 1, EXP_BOTTOM | EXP_RIGHT));
    add_row(pixel_row(4095, 0, 0, 0, 0, 0, 0, 1, EXP_TOP | EXP_RIGHT));
    // Zero scale still emits points, all at the origin.
    add_row(write_row(CFG_PIXEL_SCALE, 0));
    add_row(pixel_row(7, 9, 0, 5, 5, 5, 5, 1, EXP_ALL));
    // One-pixel region in the far corner.
    add_row(write_row(CFG_PIXEL_SCALE, 65536));
    add_row(write_row(CFG_REGION_START_X, 4095));
    add_row(write_row(CFG_REGION_START_Y, 4095));
    add_row(write_row(CFG_REGION_WIDTH, 1));
    add_row(write_row(CFG_REGION_HEIGHT, 1));
    add_row(pixel_row(4095, 4095, 0, 0, 0, 0, 0, 1, EXP_BOTTOM | EXP_RIGHT));
    add_row(pixel_row(4094, 4095, 0, 0, 0, 0, 0, 1, EXP_NONE));
    // Empty region, then empty world.
    add_row(write_row(CFG_REGION_WIDTH, 0));
    add_row(pixel_row(4095, 4095, 0, 0, 0, 0, 0, 1, EXP_NONE));
    add_row(write_row(CFG_WORLD_WIDTH, 0));
    add_row(write_row(CFG_REGION_START_X, 0));
    add_row(write_row(CFG_REGION_START_Y, 0));
    add_row(write_row(CFG_REGION_WIDTH, 4096));
    add_row(write_row(CFG_REGION_HEIGHT, 4096));
    add_row(pixel_row(0, 0, 0, 0, 0, 0, 0, 1, EXP_NONE));
    // Small region with a sparse mask; checked against the predictor.
    add_row(write_row(CFG_WORLD_WIDTH, 4096));
    add_row(write_row(CFG_REGION_START_X, 100));
    add_row(write_row(CFG_REGION_START_Y, 50));
    add_row(write_row(CFG_REGION_WIDTH, 20));
    add_row(write_row(CFG_REGION_HEIGHT, 30));
    add_row(write_row(CFG_PIXEL_SCALE, 24'h01_8000));
    add_row(write_row(CFG_SOLID_MASK, 64'h5555_5555_5555_5555));
    add_row(pixel_row(99, 60, 2, 3, 4, 5, 6, 0, EXP_NONE));
    add_row(pixel_row(100, 50, 2, 3, 4, 5, 6, 0, EXP_NONE));
    add_row(pixel_row(119, 79, 8, 8, 9, 8, 11, 0, EXP_NONE));
    add_row(pixel_row(120, 79, 8, 8, 8, 8, 8, 0, EXP_NONE));
    add_row(pixel_row(110, 80, 4, 4, 4, 4, 4, 0, EXP_NONE));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed plan; registers change only once the block is quiet.
    pending = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (pending) begin
          settle();
          pending = 1'b0;
        end
        write_reg(plan[i].idx, plan[i].data);
        if (i + 1 == plan.size() || plan[i + 1].kind != ROW_WRITE)
          cfg_valid <= 1'b0;
      end else begin
        send_pixel(plan[i].pix, plan[i].typed, plan[i].sides);
        pending = 1'b1;
      end
    end

    // Random phases: fresh register settings, then a burst of random pixels.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      ww = ($urandom_range(0, 2) == 0) ? 4096 : $urandom_range(1, 4096);
      wh = ($urandom_range(0, 2) == 0) ? 4096 : $urandom_range(1, 4096);
      if (ph == 0) begin
        ww = 4096;
        wh = 4096;
      end else if (ph == PHASES - 1) begin
        // Tiny world: the border cases come up often.
        ww = $urandom_range(1, 8);
        wh = $urandom_range(1, 8);
      end
      sx = $urandom_range(0, ww - 1);
      sy = $urandom_range(0, wh - 1);
      rw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(1, 64);
      rh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(1, 64);
      if (ph == 0) begin
        sx = 0;
        sy = 0;
        rw = 4096;
        rh = 4096;
      end
      vals[CFG_WORLD_WIDTH]    = ww;
      vals[CFG_WORLD_HEIGHT]   = wh;
      vals[CFG_REGION_START_X] = sx;
      vals[CFG_REGION_START_Y] = sy;
      vals[CFG_REGION_WIDTH]   = rw;
      vals[CFG_REGION_HEIGHT]  = rh;
      vals[CFG_PIXEL_SCALE]    = (ph == 0) ? 24'hFF_FFFF : $urandom_range(0, 24'hFF_FFFF);
      vals[CFG_SOLID_MASK]     = {$urandom, $urandom};
      if (ph % 2 == 1)
        vals[CFG_SOLID_MASK] |= {$urandom, $urandom};
      for (int r = 0; r < 8; r++)
        write_reg(cfg_reg_t'(r), vals[r]);
      cfg_valid <= 1'b0;
      // Back the block up once while pixels keep coming.
      if (ph == 1)
        hold_off_req = 1'b1;
      repeat (PER_PHASE) send_pixel(rand_pixel(), 1'b0, EXP_NONE);
    end

    settle();
    if (fails == 0)
      $display("solid_pixel_boundary_edges: match");
    else
      $display("solid_pixel_boundary_edges: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
src/spbe_pkg.sv
src/spbe_emit.sv
src/solid_pixel_boundary_edges.sv
sim/testbench.sv
